/* hw/rtl/mppt_pkg.sv */
// ----------------------------------------------------------------------------
// mppt_pkg
// Shared types, register codes and constants of the sweep and P&O tracker.
// ----------------------------------------------------------------------------
package mppt_pkg;

  localparam int unsigned PowW    = 40;
  localparam int unsigned MvW     = 16;
  localparam int unsigned DutyW   = 16;
  localparam int unsigned SDutyW  = 17;
  localparam int unsigned StepW   = 12;
  localparam int unsigned DeltaW  = 13;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 40;

  localparam logic [SDutyW-1:0] SweepStep = 17'd16;

  // residue folding of the threshold modulo 1000, ten bits per chunk
  localparam int unsigned Thousand = 1000;
  localparam int unsigned Fold1    = (1 << 10) % Thousand;
  localparam int unsigned Fold2    = (1 << 20) % Thousand;
  localparam int unsigned Fold3    = (1 << 30) % Thousand;

  localparam logic [StepW-1:0]        RstTrackStep = 12'd8;
  localparam logic [PowW-1:0]         RstThreshold = 40'd100000;
  localparam logic [DutyW-1:0]        RstDutyMax   = 16'hFFFF;
  localparam logic [MvW-1:0]          RstVinMin    = 16'h0000;
  localparam logic [MvW-1:0]          RstVinMax    = 16'hFFFF;
  localparam logic [MvW-1:0]          RstVoutMax   = 16'hFFFF;
  localparam logic signed [MvW-1:0]   RstIoutMax   = 16'sh7FFF;
  localparam logic signed [MvW-1:0]   RstIoutMin   = 16'sh8000;

  typedef enum logic [1:0] {
    ActStartSweep,
    ActSweepSample,
    ActStartTrack,
    ActTrackSample
  } action_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTrackStep,
    CfgThreshold,
    CfgDutyMax,
    CfgVinMin,
    CfgVinMax,
    CfgVoutMax,
    CfgIoutMax,
    CfgIoutMin
  } cfg_idx_t;

  typedef struct packed {
    action_t                  action;
    logic [DutyW-1:0]         start_duty;
    logic [PowW-1:0]          power_in_uw;
    logic [PowW-1:0]          power_out_uw;
    logic [MvW-1:0]           vin_mv;
    logic [MvW-1:0]           vout_mv;
    logic signed [MvW-1:0]    iout_ma;
  } item_t;

  typedef struct packed {
    item_t             item;
    logic [PowW:0]     up_sum;
    logic [PowW-1:0]   dn_diff;
    logic              dn_ok;
  } trk_t;

endpackage

/* hw/rtl/mppt_item_if.sv */
// ----------------------------------------------------------------------------
// mppt_item_if
// Measurement channel: one beat carries an action and its samples.
// ----------------------------------------------------------------------------
interface mppt_item_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         action;
  logic [mppt_pkg::DutyW-1:0]         start_duty;
  logic [mppt_pkg::PowW-1:0]          power_in_uw;
  logic [mppt_pkg::PowW-1:0]          power_out_uw;
  logic [mppt_pkg::MvW-1:0]           vin_mv;
  logic [mppt_pkg::MvW-1:0]           vout_mv;
  logic signed [mppt_pkg::MvW-1:0]    iout_ma;

  modport source (output valid, action, start_duty, power_in_uw, power_out_uw,
                  vin_mv, vout_mv, iout_ma, input ready);
  modport sink   (input valid, action, start_duty, power_in_uw, power_out_uw,
                  vin_mv, vout_mv, iout_ma, output ready);
endinterface

/* hw/rtl/mppt_result_if.sv */
// ----------------------------------------------------------------------------
// mppt_result_if
// Result channel: duty or step delta for one sample beat.
// ----------------------------------------------------------------------------
interface mppt_result_if;
  logic                                 valid;
  logic                                 ready;
  logic [mppt_pkg::DutyW-1:0]           duty;
  logic signed [mppt_pkg::DeltaW-1:0]   delta;
  logic                                 finished;

  modport source (output valid, duty, delta, finished, input ready);
  modport sink   (input valid, duty, delta, finished, output ready);
endinterface

/* hw/rtl/mppt_prep.sv */
// ----------------------------------------------------------------------------
// mppt_prep
// Front pipeline: registers the beat and derives the threshold bounds
// (threshold rounded down to whole milliwatts, output power plus/minus it).
// ----------------------------------------------------------------------------
module mppt_prep (
  input  logic                        clk,
  input  logic                        rst,
  mppt_item_if.sink                   item,
  input  logic [mppt_pkg::PowW-1:0]   threshold,
  input  logic                        take,
  output logic                        trk_valid,
  output mppt_pkg::trk_t              trk
);

  logic va, vb, vc, vd, ve;
  logic free_a, free_b, free_c, free_d, free_e;

  mppt_pkg::item_t ia, ib, ic, id;
  mppt_pkg::trk_t  te;

  logic [20:0]                r1, r1_b;
  logic [15:0]                r2;
  logic [10:0]                r3;
  logic [9:0]                 rmod, rmod_c;
  logic [mppt_pkg::PowW-1:0]  tf, tf_d;
  logic [mppt_pkg::PowW:0]    up_sum, dn_wide;

  assign free_e = !ve || take;
  assign free_d = !vd || free_e;
  assign free_c = !vc || free_d;
  assign free_b = !vb || free_c;
  assign free_a = !va || free_b;
  assign item.ready = free_a;

  assign r1 = 21'(threshold[9:0])
            + 21'(threshold[19:10]) * 21'(mppt_pkg::Fold1)
            + 21'(threshold[29:20]) * 21'(mppt_pkg::Fold2)
            + 21'(threshold[39:30]) * 21'(mppt_pkg::Fold3);

  assign r2   = 16'(r1_b[9:0]) + 16'(r1_b[20:10]) * 16'(mppt_pkg::Fold1);
  assign r3   = 11'(r2[9:0]) + 11'(r2[15:10]) * 11'(mppt_pkg::Fold1);
  assign rmod = (r3 >= 11'(mppt_pkg::Thousand)) ? 10'(r3 - 11'(mppt_pkg::Thousand))
                                                : r3[9:0];

  assign tf = threshold - 40'(rmod_c);

  assign up_sum  = {1'b0, id.power_out_uw} + {1'b0, tf_d};
  assign dn_wide = {1'b0, id.power_out_uw} - {1'b0, tf_d};

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
    end else begin
      if (free_a) va <= item.valid;
      if (free_b) vb <= va;
      if (free_c) vc <= vb;
      if (free_d) vd <= vc;
      if (free_e) ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (free_a) begin
      ia.action       <= mppt_pkg::action_t'(item.action);
      ia.start_duty   <= item.start_duty;
      ia.power_in_uw  <= item.power_in_uw;
      ia.power_out_uw <= item.power_out_uw;
      ia.vin_mv       <= item.vin_mv;
      ia.vout_mv      <= item.vout_mv;
      ia.iout_ma      <= item.iout_ma;
    end
    if (free_b) begin
      ib   <= ia;
      r1_b <= r1;
    end
    if (free_c) begin
      ic     <= ib;
      rmod_c <= rmod;
    end
    if (free_d) begin
      id   <= ic;
      tf_d <= tf;
    end
    if (free_e) begin
      te.item    <= id;
      te.up_sum  <= up_sum;
      te.dn_diff <= dn_wide[mppt_pkg::PowW-1:0];
      te.dn_ok   <= !dn_wide[mppt_pkg::PowW];
    end
  end

  assign trk_valid = ve;
  assign trk       = te;

endmodule

/* hw/rtl/mppt_sweep_and_perturb_observe.sv */
// ----------------------------------------------------------------------------
// mppt_sweep_and_perturb_observe
// Sweep-then-track maximum power point tracker (perturb and observe).
//
//   channel  dir  beat contents
//   item     in   action, start_duty, power_in/out_uw, vin/vout_mv, iout_ma
//   result   out  duty, delta, finished (sample actions only)
//   cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// A beat passes the mppt_prep stages and the output register to result; one
// beat per cycle sustained while results are taken. The sweep and tracking
// state updates in the last stage. Synchronous reset restores the register
// defaults and clears the state but sets the direction to up. A stalled result
// holds in the output register; the front stages fill, then item.ready drops.
// ----------------------------------------------------------------------------
module mppt_sweep_and_perturb_observe (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mppt_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [mppt_pkg::CfgW-1:0]      cfg_data,
  mppt_item_if.sink                      item,
  mppt_result_if.source                  result
);

  logic [mppt_pkg::StepW-1:0]       track_step;
  logic [mppt_pkg::PowW-1:0]        threshold;
  logic [mppt_pkg::DutyW-1:0]       duty_max;
  logic [mppt_pkg::MvW-1:0]         vin_min;
  logic [mppt_pkg::MvW-1:0]         vin_max;
  logic [mppt_pkg::MvW-1:0]         vout_max;
  logic signed [mppt_pkg::MvW-1:0]  iout_max;
  logic signed [mppt_pkg::MvW-1:0]  iout_min;

  logic [mppt_pkg::PowW-1:0]    baseline, baseline_next;
  logic                         going_up, going_up_next;
  logic [mppt_pkg::SDutyW-1:0]  sweep_duty, sweep_duty_next;
  logic [mppt_pkg::PowW-1:0]    best_power, best_power_next;
  logic [mppt_pkg::DutyW-1:0]   best_duty, best_duty_next;

  logic                         trk_valid;
  mppt_pkg::trk_t               trk;
  mppt_pkg::action_t            act;
  logic signed [mppt_pkg::MvW-1:0] e_iout;
  logic                         has_res, take;

  logic                         fault, better, done, drop, sig;
  logic [mppt_pkg::SDutyW:0]    duty_step;
  logic [mppt_pkg::SDutyW-1:0]  duty_sat;
  logic [mppt_pkg::DutyW-1:0]   best_sat;

  logic                               res_valid;
  logic [mppt_pkg::DutyW-1:0]         res_duty, r_duty;
  logic signed [mppt_pkg::DeltaW-1:0] res_delta, r_delta;
  logic                               res_fin, r_fin;

  mppt_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .threshold (threshold),
    .take      (take),
    .trk_valid (trk_valid),
    .trk       (trk)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      track_step <= mppt_pkg::RstTrackStep;
      threshold  <= mppt_pkg::RstThreshold;
      duty_max   <= mppt_pkg::RstDutyMax;
      vin_min    <= mppt_pkg::RstVinMin;
      vin_max    <= mppt_pkg::RstVinMax;
      vout_max   <= mppt_pkg::RstVoutMax;
      iout_max   <= mppt_pkg::RstIoutMax;
      iout_min   <= mppt_pkg::RstIoutMin;
    end else if (cfg_we) begin
      unique case (mppt_pkg::cfg_idx_t'(cfg_index))
        mppt_pkg::CfgTrackStep: track_step <= cfg_data[mppt_pkg::StepW-1:0];
        mppt_pkg::CfgThreshold: threshold  <= cfg_data[mppt_pkg::PowW-1:0];
        mppt_pkg::CfgDutyMax:   duty_max   <= cfg_data[mppt_pkg::DutyW-1:0];
        mppt_pkg::CfgVinMin:    vin_min    <= cfg_data[mppt_pkg::MvW-1:0];
        mppt_pkg::CfgVinMax:    vin_max    <= cfg_data[mppt_pkg::MvW-1:0];
        mppt_pkg::CfgVoutMax:   vout_max   <= cfg_data[mppt_pkg::MvW-1:0];
        mppt_pkg::CfgIoutMax:   iout_max   <= cfg_data[mppt_pkg::MvW-1:0];
        mppt_pkg::CfgIoutMin:   iout_min   <= cfg_data[mppt_pkg::MvW-1:0];
      endcase
    end
  end

  assign act     = trk.item.action;
  assign e_iout  = trk.item.iout_ma;
  assign has_res = (act == mppt_pkg::ActSweepSample) || (act == mppt_pkg::ActTrackSample);
  assign take    = trk_valid && (!has_res || !res_valid || result.ready);

  assign fault = (trk.item.vin_mv < vin_min) || (trk.item.vout_mv >= vout_max) ||
                 (e_iout >= iout_max) || (e_iout <= iout_min) ||
                 (trk.item.vin_mv >= vin_max);
  assign better    = trk.item.power_in_uw > best_power;
  assign duty_step = {1'b0, sweep_duty} + {1'b0, mppt_pkg::SweepStep};
  assign duty_sat  = duty_step[mppt_pkg::SDutyW] ? '1 : duty_step[mppt_pkg::SDutyW-1:0];
  assign best_sat  = sweep_duty[mppt_pkg::SDutyW-1] ? '1 : sweep_duty[mppt_pkg::DutyW-1:0];

  // a change counts once it reaches the threshold rounded down to whole mW
  assign drop = trk.item.power_out_uw < baseline;
  assign sig  = drop ? ({1'b0, baseline} >= trk.up_sum)
                     : (trk.dn_ok && (trk.dn_diff >= baseline));

  always_comb begin
    baseline_next   = baseline;
    going_up_next   = going_up;
    sweep_duty_next = sweep_duty;
    best_power_next = best_power;
    best_duty_next  = best_duty;
    done            = 1'b0;
    r_duty          = '0;
    r_delta         = '0;
    r_fin           = 1'b0;
    unique case (act)
      mppt_pkg::ActStartSweep: begin
        sweep_duty_next = {1'b0, trk.item.start_duty};
        best_power_next = '0;
        best_duty_next  = trk.item.start_duty;
      end
      mppt_pkg::ActSweepSample: begin
        if (fault) begin
          done = 1'b1;
        end else begin
          if (better) begin
            best_power_next = trk.item.power_in_uw;
            best_duty_next  = best_sat;
          end
          sweep_duty_next = duty_sat;
          done            = duty_sat > {1'b0, duty_max};
        end
        r_fin  = done;
        r_duty = done ? best_duty_next : duty_sat[mppt_pkg::DutyW-1:0];
      end
      mppt_pkg::ActStartTrack: begin
        baseline_next = trk.item.power_in_uw;
      end
      mppt_pkg::ActTrackSample: begin
        if (sig) begin
          if (drop) going_up_next = !going_up;
          baseline_next = trk.item.power_out_uw;
        end
        r_delta = going_up_next ? $signed({1'b0, track_step})
                                : $signed(13'd0 - {1'b0, track_step});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline   <= '0;
      going_up   <= 1'b1;
      sweep_duty <= '0;
      best_power <= '0;
      best_duty  <= '0;
    end else if (take) begin
      baseline   <= baseline_next;
      going_up   <= going_up_next;
      sweep_duty <= sweep_duty_next;
      best_power <= best_power_next;
      best_duty  <= best_duty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take && has_res) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && has_res) begin
      res_duty  <= r_duty;
      res_delta <= r_delta;
      res_fin   <= r_fin;
    end
  end

  assign result.valid    = res_valid;
  assign result.duty     = res_duty;
  assign result.delta    = res_delta;
  assign result.finished = res_fin;

  a_dir_only_on_track: assert property (@(posedge clk) disable iff (rst)
    !(take && (act == mppt_pkg::ActTrackSample)) |=> going_up == $past(going_up))
    else $error("direction changed outside a track sample");

  a_sweep_monotonic: assert property (@(posedge clk) disable iff (rst)
    (take && (act == mppt_pkg::ActSweepSample)) |=> sweep_duty >= $past(sweep_duty))
    else $error("sweep duty moved backwards on a sample");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (take && has_res) |=> res_valid)
    else $error("sample beat taken without a result");

  a_finished_no_delta: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_fin) |-> (res_delta == '0))
    else $error("finished sweep result carries a delta");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !result.ready) |-> !(take && has_res))
    else $error("pending result overwritten");

endmodule

/* tb/mppt_sweep_and_perturb_observe_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mppt_sweep_and_perturb_observe_checker
// Watches the item, result and register channels of the tracker and keeps
// its own copy of the sweep and tracking state. Each accepted sample beat
// yields the duty or step delta the tracker must report. Each result beat is
// compared in order against those reports.
// ----------------------------------------------------------------------------
module mppt_sweep_and_perturb_observe_checker
  import mppt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  mppt_item_if               item,
  mppt_result_if             result,
  output int                 fail_count,
  output int                 awaiting
);

  typedef struct packed {
    logic [DutyW-1:0]         duty;
    logic signed [DeltaW-1:0] delta;
    logic                     finished;
  } report_t;

  report_t reports_due[$];

  logic [StepW-1:0]        step_sz;
  logic [PowW-1:0]         thr_uw;
  logic [DutyW-1:0]        duty_lim;
  logic [MvW-1:0]          vin_lo;
  logic [MvW-1:0]          vin_hi;
  logic [MvW-1:0]          vout_hi;
  logic signed [MvW-1:0]   iout_hi;
  logic signed [MvW-1:0]   iout_lo;

  logic [PowW-1:0]         base_pw;
  logic                    rising;
  logic [SDutyW-1:0]       sw_duty;
  logic [PowW-1:0]         best_pw;
  logic [DutyW-1:0]        best_duty;

  task automatic advance_mppt(input item_t it);
    report_t           r;
    logic              ends;
    logic [SDutyW:0]   nxt;
    logic              drop;
    logic [PowW-1:0]   mag;
    r = '0;
    case (it.action)
      ActStartSweep: begin
        sw_duty   = {1'b0, it.start_duty};
        best_pw   = '0;
        best_duty = it.start_duty;
      end
      ActStartTrack: begin
        base_pw = it.power_in_uw;
      end
      ActSweepSample: begin
        ends = (it.vin_mv < vin_lo) || (it.vout_mv >= vout_hi) ||
               (it.iout_ma >= iout_hi) || (it.iout_ma <= iout_lo) ||
               (it.vin_mv >= vin_hi);
        if (!ends) begin
          if (it.power_in_uw > best_pw) begin
            best_pw   = it.power_in_uw;
            best_duty = sw_duty[SDutyW-1] ? '1 : sw_duty[DutyW-1:0];
          end
          nxt     = {1'b0, sw_duty} + {1'b0, SweepStep};
          sw_duty = nxt[SDutyW] ? '1 : nxt[SDutyW-1:0];
          ends    = sw_duty > {1'b0, duty_lim};
        end
        r.duty     = ends ? best_duty : sw_duty[DutyW-1:0];
        r.finished = ends;
        reports_due.push_back(r);
      end
      default: begin
        // millwatt-truncated threshold on the size of the change
        drop = it.power_out_uw < base_pw;
        mag  = drop ? base_pw - it.power_out_uw : it.power_out_uw - base_pw;
        if (mag / PowW'(Thousand) >= thr_uw / PowW'(Thousand)) begin
          if (drop) rising = !rising;
          base_pw = it.power_out_uw;
        end
        r.delta = {1'b0, step_sz};
        if (!rising) r.delta = -r.delta;
        reports_due.push_back(r);
      end
    endcase
  endtask

  always @(posedge clk) begin
    report_t want;
    item_t   seen;
    if (rst) begin
      step_sz   = RstTrackStep;
      thr_uw    = RstThreshold;
      duty_lim  = RstDutyMax;
      vin_lo    = RstVinMin;
      vin_hi    = RstVinMax;
      vout_hi   = RstVoutMax;
      iout_hi   = RstIoutMax;
      iout_lo   = RstIoutMin;
      base_pw   = '0;
      rising    = 1'b1;
      sw_duty   = '0;
      best_pw   = '0;
      best_duty = '0;
      reports_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CfgTrackStep: step_sz  = cfg_data[StepW-1:0];
          CfgThreshold: thr_uw   = cfg_data[PowW-1:0];
          CfgDutyMax:   duty_lim = cfg_data[DutyW-1:0];
          CfgVinMin:    vin_lo   = cfg_data[MvW-1:0];
          CfgVinMax:    vin_hi   = cfg_data[MvW-1:0];
          CfgVoutMax:   vout_hi  = cfg_data[MvW-1:0];
          CfgIoutMax:   iout_hi  = cfg_data[MvW-1:0];
          CfgIoutMin:   iout_lo  = cfg_data[MvW-1:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (reports_due.size() == 0) begin
          $error("result beat with nothing awaited: duty %0d delta %0d finished %0d",
                 result.duty, result.delta, result.finished);
          fail_count++;
        end else begin
          want = reports_due.pop_front();
          if (result.duty !== want.duty) begin
            $error("duty: expected %0d, got %0d", want.duty, result.duty);
            fail_count++;
          end
          if (result.delta !== want.delta) begin
            $error("delta: expected %0d, got %0d", want.delta, result.delta);
            fail_count++;
          end
          if (result.finished !== want.finished) begin
            $error("finished: expected %0d, got %0d", want.finished, result.finished);
            fail_count++;
          end
        end
      end
      if (item.valid && item.ready) begin
        seen.action       = action_t'(item.action);
        seen.start_duty   = item.start_duty;
        seen.power_in_uw  = item.power_in_uw;
        seen.power_out_uw = item.power_out_uw;
        seen.vin_mv       = item.vin_mv;
        seen.vout_mv      = item.vout_mv;
        seen.iout_ma      = item.iout_ma;
        advance_mppt(seen);
      end
    end
    awaiting = reports_due.size();
  end

endmodule

/* tb/tb_mppt_sweep_and_perturb_observe.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mppt_sweep_and_perturb_observe
// Drives the sweep and P&O tracker with a directed set of limit, extreme and
// threshold cases, then with random sweep runs, tracking runs and stray beats
// under several register settings and handshake idling patterns. A sweep
// past the end of the duty range closes the run. The checker beside the
// block reports failures; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_mppt_sweep_and_perturb_observe;
  import mppt_pkg::*;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_data;
  int                 fail_count;
  int                 awaiting;
  int                 gap_pct;
  int                 stall_pct;
  int                 beats_sent;

  logic [PowW-1:0]        thr_set;
  logic [DutyW-1:0]       dmax_set;
  logic [MvW-1:0]         vmin_set;
  logic [MvW-1:0]         vmax_set;
  logic [MvW-1:0]         vomax_set;
  logic signed [MvW-1:0]  imax_set;
  logic signed [MvW-1:0]  imin_set;

  mppt_item_if   item();
  mppt_result_if result();

  mppt_sweep_and_perturb_observe uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .result    (result)
  );

  mppt_sweep_and_perturb_observe_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item       (item),
    .result     (result),
    .fail_count (fail_count),
    .awaiting   (awaiting)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    result.ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #1_000_000;
    $display("mppt_sweep_and_perturb_observe verification failed");
    $finish;
  end

  function automatic logic [PowW-1:0] rand_pow();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(7))
      0: w = '0;
      1: w = '1;
      2: w = 64'($urandom_range(2000000));
      default: ;
    endcase
    return w[PowW-1:0];
  endfunction

  function automatic item_t compose(action_t act, logic [DutyW-1:0] sd,
                                    logic [PowW-1:0] pin, logic [PowW-1:0] pout,
                                    logic [MvW-1:0] vin, logic [MvW-1:0] vout,
                                    logic signed [MvW-1:0] iout);
    item_t it;
    it.action       = act;
    it.start_duty   = sd;
    it.power_in_uw  = pin;
    it.power_out_uw = pout;
    it.vin_mv       = vin;
    it.vout_mv      = vout;
    it.iout_ma      = iout;
    return it;
  endfunction

  function automatic item_t noise_item();
    return compose(action_t'($urandom_range(3)), DutyW'($urandom), rand_pow(), rand_pow(),
                   MvW'($urandom), MvW'($urandom), MvW'($urandom));
  endfunction

  // keep the measurements inside the current sweep limits where possible
  function automatic item_t in_window(item_t it);
    int lo;
    int hi;
    if (vmax_set > vmin_set) it.vin_mv = MvW'($urandom_range(vmax_set - 1, vmin_set));
    if (vomax_set != 0) it.vout_mv = MvW'($urandom_range(vomax_set - 1, 0));
    lo = int'(imin_set) + 1;
    hi = int'(imax_set) - 1;
    if (hi >= lo) it.iout_ma = MvW'(lo + int'($urandom_range(hi - lo)));
    return it;
  endfunction

  task automatic send(input item_t it);
    while ($urandom_range(99) < gap_pct) begin
      item.valid <= 1'b0;
      @(posedge clk);
    end
    item.valid        <= 1'b1;
    item.action       <= it.action;
    item.start_duty   <= it.start_duty;
    item.power_in_uw  <= it.power_in_uw;
    item.power_out_uw <= it.power_out_uw;
    item.vin_mv       <= it.vin_mv;
    item.vout_mv      <= it.vout_mv;
    item.iout_ma      <= it.iout_ma;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    beats_sent++;
  endtask

  // hold the sender until every report is back, then let the pipe empty
  task automatic drain();
    item.valid <= 1'b0;
    @(negedge clk);
    while (awaiting != 0) @(negedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CfgW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  task automatic program_limits(input int ph);
    logic [StepW-1:0] step;
    case (ph)
      0: begin
        step = RstTrackStep;    thr_set = RstThreshold;  dmax_set = RstDutyMax;
        vmin_set = RstVinMin;   vmax_set = RstVinMax;    vomax_set = RstVoutMax;
        imax_set = RstIoutMax;  imin_set = RstIoutMin;
      end
      1: begin
        step = '1;              thr_set = '0;            dmax_set = '0;
        vmin_set = '0;          vmax_set = '1;           vomax_set = '1;
        imax_set = 16'sh7FFF;   imin_set = 16'sh8000;
      end
      2: begin
        step = '0;              thr_set = '1;            dmax_set = '1;
        vmin_set = '1;          vmax_set = '0;           vomax_set = '0;
        imax_set = 16'sh8000;   imin_set = 16'sh7FFF;
      end
      default: begin
        step      = StepW'($urandom_range(4095));
        thr_set   = $urandom_range(1) ? PowW'($urandom_range(500000)) : rand_pow();
        dmax_set  = $urandom_range(1) ? 16'hFFFF : 16'($urandom);
        vmin_set  = MvW'($urandom_range(20000));
        vmax_set  = MvW'($urandom_range(65535, 30000));
        vomax_set = MvW'($urandom_range(65535, 20000));
        imax_set  = MvW'($urandom_range(32767, 100));
        imin_set  = MvW'(-int'($urandom_range(32768, 100)));
      end
    endcase
    write_reg(CfgTrackStep, CfgW'(step));
    write_reg(CfgThreshold, CfgW'(thr_set));
    write_reg(CfgDutyMax, CfgW'(dmax_set));
    write_reg(CfgVinMin, CfgW'(vmin_set));
    write_reg(CfgVinMax, CfgW'(vmax_set));
    write_reg(CfgVoutMax, CfgW'(vomax_set));
    write_reg(CfgIoutMax, CfgW'(imax_set));
    write_reg(CfgIoutMin, CfgW'(imin_set));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_sweep(input int count);
    item_t it;
    int    sd;
    it = noise_item();
    it.action = ActStartSweep;
    case ($urandom_range(3))
      0, 1: it.start_duty = DutyW'($urandom_range(dmax_set));
      2: begin
        sd = int'(dmax_set) - int'($urandom_range(16 * count));
        it.start_duty = (sd < 0) ? '0 : DutyW'(sd);
      end
      default: ;
    endcase
    send(it);
    repeat (count) begin
      it = noise_item();
      it.action = ActSweepSample;
      if ($urandom_range(9) != 0) it = in_window(it);
      send(it);
    end
  endtask

  task automatic run_track(input int count);
    item_t           it;
    logic [PowW-1:0] level;
    logic [63:0]     span;
    logic [63:0]     shift;
    it = noise_item();
    it.action = ActStartTrack;
    level = it.power_in_uw;
    send(it);
    repeat (count) begin
      it = noise_item();
      it.action = ActTrackSample;
      span  = (thr_set == 0) ? 64'd5000 : 64'(thr_set);
      shift = span * 64'($urandom_range(250)) / 64'd100;
      if ($urandom_range(1)) begin
        level = (64'(level) + shift > 64'(PowW'('1))) ? '1 : level + PowW'(shift);
      end else begin
        level = (shift > 64'(level)) ? '0 : level - PowW'(shift);
      end
      if ($urandom_range(9) == 0) level = rand_pow();
      it.power_out_uw = level;
      send(it);
    end
  endtask

  initial begin
    int target;
    gap_pct    = 0;
    stall_pct  = 0;
    beats_sent = 0;
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_index  <= CfgTrackStep;
    cfg_data   <= '0;
    item.valid        <= 1'b0;
    item.action       <= ActStartSweep;
    item.start_duty   <= '0;
    item.power_in_uw  <= '0;
    item.power_out_uw <= '0;
    item.vin_mv       <= '0;
    item.vout_mv      <= '0;
    item.iout_ma      <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(compose(ActStartSweep, 16'h0000, '0, '0, '0, '0, '0));
    send(compose(ActSweepSample, '0, '1, '1, 16'd1000, 16'd1000, 16'sd0));
    send(compose(ActSweepSample, '0, '0, '0, 16'd0, 16'd0, 16'sd5));
    send(compose(ActSweepSample, '0, 40'd7, '0, 16'hFFFF, 16'd10, 16'sd0));
    send(compose(ActSweepSample, '0, 40'd7, '0, 16'd10, 16'hFFFF, 16'sd0));
    send(compose(ActSweepSample, '0, 40'd7, '0, 16'd10, 16'd10, 16'sh7FFF));
    send(compose(ActSweepSample, '0, 40'd7, '0, 16'd10, 16'd10, 16'sh8000));
    send(compose(ActStartSweep, 16'hFFFF, '1, '1, '1, '1, '1));
    send(compose(ActSweepSample, '0, 40'd5, '0, 16'd10, 16'd10, 16'sd0));
    send(compose(ActSweepSample, '0, 40'd6, '0, 16'd10, 16'd10, 16'sd0));
    send(compose(ActSweepSample, '0, 40'd9, '0, 16'd10, 16'd10, 16'sd0));
    send(compose(ActStartTrack, '0, 40'd100000, '1, '0, '0, '0));
    send(compose(ActTrackSample, '0, '1, 40'd200000, '0, '0, '0));
    send(compose(ActTrackSample, '0, '0, 40'd100001, '0, '0, '0));
    send(compose(ActTrackSample, '0, '0, 40'd100000, '0, '0, '0));
    send(compose(ActTrackSample, '0, '0, 40'd0, '0, '0, '0));
    send(compose(ActStartTrack, '0, '0, '0, '0, '0, '0));
    send(compose(ActTrackSample, '0, '0, '1, '0, '0, '0));
    send(compose(ActTrackSample, '0, '0, '0, '0, '0, '0));

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      program_limits(ph);
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 58; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 58; end
        default: begin gap_pct = 29; stall_pct = 29; end
      endcase
      repeat (2) begin
        target = beats_sent + 38;
        while (beats_sent < target) begin
          case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6, 7, 8: run_sweep($urandom_range(40, 1));
            9, 10, 11, 12, 13, 14, 15, 16: run_track($urandom_range(30, 1));
            default: send(noise_item());
          endcase
        end
        drain();
      end
    end

    // run the sweep past the top of the duty range
    program_limits(0);
    gap_pct   = 0;
    stall_pct = 0;
    send(compose(ActStartSweep, 16'hFFFF, '0, '0, '0, '0, '0));
    repeat (20) send(in_window(compose(ActSweepSample, DutyW'($urandom), rand_pow(),
                                       rand_pow(), MvW'($urandom), MvW'($urandom),
                                       MvW'($urandom))));
    drain();

    if (fail_count == 0 && awaiting == 0) begin
      $display("mppt_sweep_and_perturb_observe verification clean");
    end else begin
      $display("mppt_sweep_and_perturb_observe verification failed");
    end
    $finish;
  end

endmodule
